// File: rtl/atsa_pkg.sv
// Package for the ACES tone-map sample accumulator: payload types and constants.
// No dependencies; used by the top level, aces_tonemap_sample_accumulator.
package atsa_pkg;

  localparam int unsigned DefImageWidth  = 128;
  localparam int unsigned DefImageHeight = 128;
  localparam logic [15:0] LimitReset     = 16'd64;
  localparam logic [16:0] OneQ16         = 17'h10000;

  typedef struct packed {
    logic [6:0]  pixel_x;
    logic [6:0]  pixel_y;
    logic [1:0]  channel;
    logic [23:0] radiance;
    logic        last_in_frame;
  } in_item_t;

  typedef struct packed {
    logic [16:0] mean_value;
    logic [7:0]  byte_value;
    logic [15:0] frames_done;
    logic        limit_reached;
  } out_item_t;

endpackage

// File: rtl/atsa_ram.sv
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module atsa_ram #(
  parameter int unsigned WIDTH = 17,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: rtl/atsa_div.sv
// Restoring divider: QBITS quotient bits of num/den, one bit per cycle.
// No package dependency; used by the accumulator top level for both divisions.
module atsa_div #(
  parameter int unsigned NW    = 74,
  parameter int unsigned DW    = 58,
  parameter int unsigned QBITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NW-1:0]    num,
  input  logic [DW-1:0]    den,
  output logic             done,
  output logic [QBITS-1:0] quo
);

  // The quotient must fit QBITS bits, so num[NW-1:QBITS] < den and the upper part
  // of the numerator can seed the remainder directly.
  localparam int unsigned RW = DW + 1;
  localparam int unsigned CW = $clog2(QBITS + 1);

  logic [RW-1:0]    rem_r, rem_nxt;
  logic [QBITS-1:0] sh_r, sh_nxt;
  logic [DW-1:0]    den_r;
  logic [QBITS-1:0] quo_r, quo_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt, done_r, done_nxt;
  logic [RW-1:0]    trial;

  always_comb begin
    rem_nxt  = rem_r;
    sh_nxt   = sh_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[RW-2:0], sh_r[QBITS-1]};
    if (start) begin
      rem_nxt  = RW'(num[NW-1:QBITS]);
      sh_nxt   = num[QBITS-1:0];
      quo_nxt  = '0;
      cnt_nxt  = CW'(QBITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      sh_nxt = {sh_r[QBITS-2:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        quo_nxt = {quo_r[QBITS-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[QBITS-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    sh_r  <= sh_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// File: rtl/aces_tonemap_sample_accumulator.sv
// Top level of the ACES tone-map sample accumulator.
// Depends on atsa_pkg, atsa_ram and atsa_div.

// One item is one radiance sample of one colour channel of one pixel. The block maps it
// through the ACES filmic curve into Q1.16, folds it into that entry's running mean
// held in a single-port RAM of IMAGE_WIDTH*IMAGE_HEIGHT*3 entries, and returns one
// result item per input item. Items are handled one at a time. An accumulated item
// passes through the curve check, the curve division, the RAM read, the start of the
// mean division, the mean division, the write-back, the byte value and the output
// register, and is then offered as a result; the next item can be taken while it is
// offered. Each division runs on a restoring divider that produces one quotient bit
// per cycle (16 and 17 bits). When the curve saturates at 1.0 the curve division is
// skipped. Ignored and out-of-range items skip both divisions and the write-back. An
// item waits in the byte step while the previous result is stalled. The RAM needs no
// clearing pass: an entry first accumulated in frame zero ignores what it reads,
// since its old mean carries zero weight. The frame limit may be written whenever
// the block is idle.
module aces_tonemap_sample_accumulator #(
  parameter int unsigned IMAGE_WIDTH  = atsa_pkg::DefImageWidth,
  parameter int unsigned IMAGE_HEIGHT = atsa_pkg::DefImageHeight
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  atsa_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output atsa_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data
);

  localparam int unsigned DEPTH = IMAGE_WIDTH * IMAGE_HEIGHT * 3;
  localparam int unsigned AW    = $clog2(DEPTH);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CURVE = 9'b000000010,
    S_CDIV  = 9'b000000100,
    S_READ  = 9'b000001000,
    S_MUL   = 9'b000010000,
    S_MDIV  = 9'b000100000,
    S_WRITE = 9'b001000000,
    S_BYTE  = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t              state_r, state_nxt;
  atsa_pkg::in_item_t  item_r;
  logic [15:0]         limit_r, frames_r;
  logic                at_limit_r, pos_ok_r;
  logic [AW-1:0]       addr_r;
  logic [57:0]         num_r, den_r;
  logic                curve_sat;
  logic [16:0]         t_r, mean_r;
  logic [49:0]         sum_r;
  logic                out_valid_r;
  atsa_pkg::out_item_t out_r;

  logic        ram_we;
  logic [16:0] ram_rdata;
  logic        cdiv_start, cdiv_done, mdiv_start, mdiv_done;
  logic [15:0] cdiv_q;
  logic [16:0] mdiv_q;
  logic        accept;

  // Address of the entry: (y*W + x)*3 + channel, computed once per item.
  logic [AW+1:0] addr_calc;
  assign addr_calc = (AW+2)'((32'(in_item.pixel_y) * 32'(IMAGE_WIDTH)
                     + 32'(in_item.pixel_x)) * 32'd3 + 32'(in_item.channel));

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign ram_we    = (state_r == S_WRITE);

  // The curve saturates at 1.0 when num >= den.
  assign curve_sat = (num_r >= den_r);

  atsa_ram #(.WIDTH(17), .DEPTH(DEPTH)) u_store (
    .clk  (clk),
    .we   (ram_we),
    .addr (addr_r),
    .wdata(mean_r),
    .rdata(ram_rdata)
  );

  // Curve: 16 quotient bits of num*2^16/den, num < den.
  assign cdiv_start = (state_r == S_CURVE) && !at_limit_r && pos_ok_r && !curve_sat;
  atsa_div #(.NW(74), .DW(58), .QBITS(16)) u_cdiv (
    .clk(clk), .rst_n(rst_n), .start(cdiv_start),
    .num({num_r, 16'd0}), .den(den_r), .done(cdiv_done), .quo(cdiv_q)
  );

  // Mean: (acc*(n-1)+t)/n with n = frames+1; the sum is at most 65536*n, so the
  // quotient fits 17 bits.
  assign mdiv_start = (state_r == S_MUL);
  atsa_div #(.NW(33), .DW(17), .QBITS(17)) u_mdiv (
    .clk(clk), .rst_n(rst_n), .start(mdiv_start),
    .num(sum_r[32:0]), .den(17'(frames_r) + 17'd1),
    .done(mdiv_done), .quo(mdiv_q)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (accept) state_nxt = S_CURVE;
      S_CURVE: begin
        if (at_limit_r || !pos_ok_r) state_nxt = S_READ;
        else if (curve_sat) state_nxt = S_READ;
        else state_nxt = S_CDIV;
      end
      S_CDIV:  if (cdiv_done) state_nxt = S_READ;
      S_READ:  state_nxt = (at_limit_r || !pos_ok_r) ? S_BYTE : S_MUL;
      S_MUL:   state_nxt = S_MDIV;
      S_MDIV:  if (mdiv_done) state_nxt = S_WRITE;
      S_WRITE: state_nxt = S_BYTE;
      S_BYTE:  if (!out_valid_r || !out_stall) state_nxt = S_OUT;
      S_OUT:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      limit_r     <= atsa_pkg::LimitReset;
      frames_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_data;
      end
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_OUT) begin
        out_valid_r <= 1'b1;
        // The counter advances after the last sample of a frame, below the limit.
        if (!at_limit_r && item_r.last_in_frame && frames_r != 16'hFFFF) begin
          frames_r <= frames_r + 16'd1;
        end
      end
    end
  end

  // Datapath registers.
  logic [57:0] x58;
  assign x58 = 58'(in_item.radiance);

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        item_r     <= in_item;
        at_limit_r <= (frames_r >= limit_r);
        pos_ok_r   <= (32'(in_item.pixel_x) < 32'(IMAGE_WIDTH))
                   && (32'(in_item.pixel_y) < 32'(IMAGE_HEIGHT))
                   && (in_item.channel != 2'd3);
        addr_r     <= AW'(addr_calc);
        num_r      <= x58 * (58'd251 * x58 + 58'd196608);
        den_r      <= x58 * (58'd243 * x58 + 58'd3866624) + 58'd60129542144;
      end
      S_CURVE: begin
        t_r <= atsa_pkg::OneQ16;
      end
      S_CDIV: if (cdiv_done) t_r <= {1'b0, cdiv_q};
      S_READ: begin
        if (!pos_ok_r) mean_r <= '0;
        else mean_r <= ram_rdata;
        // In frame zero the old mean has no weight, so what was read is not used.
        sum_r <= 50'((frames_r == 16'd0) ? 17'd0 : ram_rdata) * 50'(frames_r) + 50'(t_r);
      end
      S_MDIV: if (mdiv_done) begin
        mean_r <= (mdiv_q > atsa_pkg::OneQ16) ? atsa_pkg::OneQ16 : mdiv_q;
      end
      S_BYTE: sum_r <= 50'(mean_r) * 50'd255;
      S_OUT: begin
        out_r.mean_value    <= mean_r;
        out_r.byte_value    <= sum_r[23:16];
        out_r.limit_reached <= at_limit_r;
        out_r.frames_done   <= (!at_limit_r && item_r.last_in_frame
                                && frames_r != 16'hFFFF) ? frames_r + 16'd1 : frames_r;
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule
